// File: rtl/core/fse_pkg.sv
// Shared constants, types and the sine table builder for the Fourier series evaluator.
package fse_pkg;

    localparam int MAX_HARMONICS   = 63;
    localparam int SINE_TABLE_BITS = 10;
    localparam int COEF_WIDTH      = 32;

    localparam int HIDX_W    = 6;
    localparam int TERM_W    = HIDX_W + 1;
    localparam int SINE_QTR  = 1 << SINE_TABLE_BITS;
    localparam int ROM_AW    = SINE_TABLE_BITS + 1;
    localparam int MAG_W     = 15;
    localparam int SINE_W    = MAG_W + 2;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 56;
    localparam int SERIES_W  = 48;
    localparam int A0_SHIFT  = 14;
    localparam int RND_SHIFT = 15;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef logic [MAG_W-1:0] t_sine_tab [0:SINE_QTR];

    typedef struct packed {
        logic capture;
        logic exec;
        logic init_acc;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       deg_zero;
        logic       last_term;
        logic       pipe_busy;
    } t_dp_status;

    // Degree-9 Taylor sine in Q30 with truncating products, rounded to a Q0.15 magnitude
    function automatic t_sine_tab f_sine_tab();
        t_sine_tab   tab;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] one;
        one = 64'd1 << 30;
        for (int i = 0; i <= SINE_QTR; i++) begin
            z  = (64'(i) * 64'd1686629713) >> SINE_TABLE_BITS;
            z2 = (z * z) >> 30;
            t  = one - z2 / 64'd72;
            t  = one - ((z2 * t) >> 30) / 64'd42;
            t  = one - ((z2 * t) >> 30) / 64'd20;
            t  = one - ((z2 * t) >> 30) / 64'd6;
            v  = ((((z * t) >> 30) * 64'd32767) + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[i] = v[MAG_W-1:0];
        end
        return tab;
    endfunction

endpackage

// File: rtl/core/fse_sine_rom.sv
// Quarter-wave sine magnitude table with registered read.
module fse_sine_rom (
    input  logic                          i_clk,
    input  logic [fse_pkg::ROM_AW-1:0]    i_addr,
    output logic [fse_pkg::MAG_W-1:0]     o_data
);

    localparam fse_pkg::t_sine_tab SINE_TAB = fse_pkg::f_sine_tab();

    logic [fse_pkg::MAG_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/fse_ctrl.sv
// Sequencing state machine for the Fourier series evaluator.
module fse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  fse_pkg::t_dp_status i_status,
    output fse_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RDAT  = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_RDAT;
            end
            S_RDAT: begin
                if (i_status.op == fse_pkg::OP_EVAL) begin
                    o_cmd.init_acc = 1'b1;
                    n_state = i_status.deg_zero ? S_DRAIN : S_LOOP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOOP: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_term) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // a finished result must never overwrite one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("result loaded over a pending one");

    // the result is formed only after the multiply pipeline has drained
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !i_status.pipe_busy)
        else $error("result formed with terms in flight");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("transfer not followed by execute");

endmodule

// File: rtl/core/fse_datapath.sv
// Coefficient store, phase accumulator, shared multiplier and accumulator.
module fse_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fse_pkg::t_dp_cmd              i_cmd,
    output fse_pkg::t_dp_status           o_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic [1:0]                    i_opcode,
    input  logic [5:0]                    i_coef_index,
    input  logic signed [31:0]            i_cos_coef_in,
    input  logic signed [31:0]            i_sin_coef_in,
    input  logic signed [31:0]            i_eval_point,
    output logic signed [47:0]            o_series_value,
    output logic signed [31:0]            o_cos_coef_out,
    output logic signed [31:0]            o_sin_coef_out,
    output logic                          o_index_error
);

    localparam int HW = fse_pkg::HIDX_W;
    localparam int CW = fse_pkg::COEF_WIDTH;
    localparam int DEPTH = fse_pkg::MAX_HARMONICS + 1;

    // configuration
    logic [HW-1:0] r_hcount;
    logic [31:0]   r_tpu;
    logic [HW-1:0] w_deg;

    // captured item
    logic [1:0]        r_op;
    logic [HW-1:0]     r_idx;
    logic [CW-1:0]     r_cin;
    logic [CW-1:0]     r_sin;
    logic [31:0]       r_x;
    logic              r_err;
    logic [31:0]       r_step;

    // coefficient memory, valid bits model the all-zero reset
    logic [CW-1:0] cos_mem [0:DEPTH-1];
    logic [CW-1:0] sin_mem [0:DEPTH-1];
    logic [DEPTH-1:0] r_cvalid;
    logic [CW-1:0] r_cdat;
    logic [CW-1:0] r_sdat;
    logic          r_vdat;
    logic          w_rd_en;
    logic [HW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic          w_idx_bad;

    // term sequencing
    logic [fse_pkg::TERM_W-1:0] r_term;
    logic [fse_pkg::TERM_W-1:0] w_last;
    logic [31:0]   r_ph;
    logic [31:0]   w_ph_next;
    logic [31:0]   w_ph_use;
    logic [fse_pkg::SINE_TABLE_BITS-1:0] w_tidx;
    logic [fse_pkg::ROM_AW-1:0] w_rom_addr;
    logic [fse_pkg::MAG_W-1:0]  w_rom_data;

    // pipeline
    logic r_p1, r_p2, r_is_sin1, r_neg1;
    logic signed [CW-1:0]               w_coef;
    logic signed [fse_pkg::SINE_W-1:0]  w_sine;
    logic signed [fse_pkg::PROD_W-1:0]  r_prod;
    logic signed [fse_pkg::ACC_W-1:0]   r_acc;
    logic [fse_pkg::ACC_W-1:0]          w_rnd;

    // output register
    logic signed [47:0] r_series;
    logic signed [31:0] r_cout;
    logic signed [31:0] r_sout;
    logic               r_oerr;

    assign w_deg = (r_hcount > HW'(fse_pkg::MAX_HARMONICS)) ?
                   HW'(fse_pkg::MAX_HARMONICS) : r_hcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcount <= HW'(1);
            r_tpu    <= 32'd10430;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0) begin
                r_hcount <= i_cfg_data[HW-1:0];
            end else begin
                r_tpu <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_idx <= i_coef_index;
            r_cin <= i_cos_coef_in;
            r_sin <= i_sin_coef_in;
            r_x   <= i_eval_point;
        end
        if (i_cmd.exec) begin
            r_step <= 32'(r_x * r_tpu);
            r_err  <= ((r_op == fse_pkg::OP_WRITE) || (r_op == fse_pkg::OP_READ)) && w_idx_bad;
        end
    end

    assign w_idx_bad = (r_idx > w_deg);
    assign w_wr_en   = i_cmd.exec && (r_op == fse_pkg::OP_WRITE) && !w_idx_bad;
    assign w_rd_en   = i_cmd.exec || i_cmd.issue;
    assign w_rd_addr = i_cmd.issue ? HW'(r_term[fse_pkg::TERM_W-1:1] + 1'b1) :
                       (r_op == fse_pkg::OP_READ) ? r_idx : '0;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            cos_mem[r_idx] <= r_cin;
            if (r_idx != '0) begin
                sin_mem[r_idx] <= r_sin;
            end
        end
        if (w_rd_en) begin
            r_cdat <= cos_mem[w_rd_addr];
            r_sdat <= sin_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_vdat   <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_cvalid[r_idx] <= 1'b1;
            end
            if (w_rd_en) begin
                r_vdat <= r_cvalid[w_rd_addr];
            end
        end
    end

    // cosine term advances the phase, the sine term of the same harmonic reuses it
    assign w_ph_next  = r_ph + r_step;
    assign w_ph_use   = r_term[0] ? r_ph : (w_ph_next + fse_pkg::QUARTER_TURN);
    assign w_tidx     = w_ph_use[29 -: fse_pkg::SINE_TABLE_BITS];
    assign w_rom_addr = w_ph_use[30] ?
                        fse_pkg::ROM_AW'(fse_pkg::SINE_QTR) - {1'b0, w_tidx} :
                        {1'b0, w_tidx};
    assign w_last     = fse_pkg::TERM_W'({w_deg, 1'b0} - 1'b1);

    fse_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_acc) begin
            r_ph   <= '0;
            r_term <= '0;
        end else if (i_cmd.issue) begin
            r_term <= r_term + 1'b1;
            if (!r_term[0]) begin
                r_ph <= w_ph_next;
            end
        end
        r_is_sin1 <= r_term[0];
        r_neg1    <= w_ph_use[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= i_cmd.issue;
            r_p2 <= r_p1;
        end
    end

    assign w_coef = !r_vdat ? '0 : (r_is_sin1 ? r_sdat : r_cdat);
    assign w_sine = r_neg1 ? -$signed({2'b00, w_rom_data}) : $signed({2'b00, w_rom_data});

    always_ff @(posedge i_clk) begin
        r_prod <= fse_pkg::PROD_W'(w_coef) * fse_pkg::PROD_W'(w_sine);
        if (i_cmd.init_acc) begin
            r_acc <= fse_pkg::ACC_W'($signed({(r_vdat ? r_cdat : '0),
                                              fse_pkg::A0_SHIFT'(0)}));
        end else if (r_p2) begin
            r_acc <= r_acc + fse_pkg::ACC_W'(r_prod);
        end
    end

    assign w_rnd = r_acc + fse_pkg::ACC_W'(16384);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_series <= '0;
            r_cout   <= '0;
            r_sout   <= '0;
            r_oerr   <= r_err && (r_op != fse_pkg::OP_EVAL);
            if (r_op == fse_pkg::OP_EVAL) begin
                r_series <= 48'($signed(w_rnd) >>> fse_pkg::RND_SHIFT);
                r_oerr   <= 1'b0;
            end else if ((r_op == fse_pkg::OP_READ) && !r_err && r_vdat) begin
                r_cout <= r_cdat;
                r_sout <= (r_idx != '0) ? r_sdat : '0;
            end
        end
    end

    assign o_status.op        = r_op;
    assign o_status.deg_zero  = (w_deg == '0);
    assign o_status.last_term = (r_term == w_last);
    assign o_status.pipe_busy = r_p1 || r_p2;

    assign o_series_value = r_series;
    assign o_cos_coef_out = r_cout;
    assign o_sin_coef_out = r_sout;
    assign o_index_error  = r_oerr;

endmodule

// File: rtl/core/fourier_series_evaluator_top.sv
// Top level of the truncated Fourier series evaluator.
// One item at a time. Write and read pass through capture, execute and a memory
// read before the result is loaded; an evaluation issues one cosine or sine term
// per cycle (none at degree zero) through a single shared 32x17 multiplier fed by
// the coefficient memory and the quarter-wave sine table, followed by a two-stage
// drain. The result sits in an output register until taken; a new item is accepted
// once the previous one has reached that register. Config writes are always ready.
module fourier_series_evaluator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [5:0]         i_coef_index,
    input  logic signed [31:0] i_cos_coef_in,
    input  logic signed [31:0] i_sin_coef_in,
    input  logic signed [31:0] i_eval_point,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [47:0] o_series_value,
    output logic signed [31:0] o_cos_coef_out,
    output logic signed [31:0] o_sin_coef_out,
    output logic               o_index_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    fse_pkg::t_dp_cmd    w_cmd;
    fse_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    fse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fse_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_coef_index   (i_coef_index),
        .i_cos_coef_in  (i_cos_coef_in),
        .i_sin_coef_in  (i_sin_coef_in),
        .i_eval_point   (i_eval_point),
        .o_series_value (o_series_value),
        .o_cos_coef_out (o_cos_coef_out),
        .o_sin_coef_out (o_sin_coef_out),
        .o_index_error  (o_index_error)
    );

endmodule
